// ===== src/wsid_pkg.sv =====
`default_nettype none

package wsid_pkg;

    localparam int DEFAULT_MAGNITUDE_BITS = 31;
    localparam int ARG_W                  = 32;
    localparam int QUEUE_DEPTH            = 4;
    localparam int QUEUE_AW               = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CW               = $clog2(QUEUE_DEPTH + 1);
    localparam int S_TDATA_W              = 8;
    localparam int M_TDATA_W              = 40;

    localparam logic [7:0]       CHAR_SPACE   = 8'h20;
    localparam logic [7:0]       CHAR_TAB     = 8'h09;
    localparam logic [7:0]       CHAR_NEWLINE = 8'h0A;
    localparam logic [ARG_W-1:0] EMPTY_NUMBER = 32'd999999;

    typedef enum logic [1:0] {
        CLS_SPACE   = 2'd0,
        CLS_TAB     = 2'd1,
        CLS_NEWLINE = 2'd2,
        CLS_OTHER   = 2'd3
    } class_t;

    typedef enum logic [1:0] {
        ST_OK         = 2'd0,
        ST_UNDEFINED  = 2'd1,
        ST_OVERFLOW   = 2'd2,
        ST_INCOMPLETE = 2'd3
    } status_t;

    typedef enum logic [4:0] {
        OP_PUSH     = 5'd0,
        OP_DUP      = 5'd1,
        OP_SWAP     = 5'd2,
        OP_POP      = 5'd3,
        OP_ADD      = 5'd4,
        OP_SUB      = 5'd5,
        OP_MUL      = 5'd6,
        OP_DIV      = 5'd7,
        OP_REM      = 5'd8,
        OP_STORE    = 5'd9,
        OP_RETRIEVE = 5'd10,
        OP_OUTC     = 5'd11,
        OP_OUTN     = 5'd12,
        OP_INC      = 5'd13,
        OP_INN      = 5'd14,
        OP_LABEL    = 5'd15,
        OP_CALL     = 5'd16,
        OP_JUMP     = 5'd17,
        OP_JZ       = 5'd18,
        OP_JNEG     = 5'd19,
        OP_RET      = 5'd20,
        OP_END      = 5'd21
    } opcode_t;

    typedef enum logic [15:0] {
        POS_IDLE = 16'h0001,
        POS_S    = 16'h0002,
        POS_SL   = 16'h0004,
        POS_T    = 16'h0008,
        POS_TS   = 16'h0010,
        POS_TSS  = 16'h0020,
        POS_TST  = 16'h0040,
        POS_TT   = 16'h0080,
        POS_TL   = 16'h0100,
        POS_TLS  = 16'h0200,
        POS_TLT  = 16'h0400,
        POS_L    = 16'h0800,
        POS_LS   = 16'h1000,
        POS_LT   = 16'h2000,
        POS_LL   = 16'h4000,
        POS_NUM  = 16'h8000
    } pos_t;

    typedef enum logic [1:0] {
        ACT_MOVE = 2'd0,
        ACT_EMIT = 2'd1,
        ACT_ARG  = 2'd2,
        ACT_ERR  = 2'd3
    } act_kind_t;

    typedef struct packed {
        act_kind_t kind;
        pos_t      next_pos;
        opcode_t   opcode;
    } action_t;

    typedef struct packed {
        class_t cls;
        logic   last;
    } qitem_t;

    typedef struct packed {
        status_t          status;
        logic             has_argument;
        logic [ARG_W-1:0] argument;
        opcode_t          opcode;
    } result_t;

    function automatic action_t act_move(pos_t p);
        action_t a;
        a.kind     = ACT_MOVE;
        a.next_pos = p;
        a.opcode   = OP_PUSH;
        return a;
    endfunction

    function automatic action_t act_emit(opcode_t op);
        action_t a;
        a.kind     = ACT_EMIT;
        a.next_pos = POS_IDLE;
        a.opcode   = op;
        return a;
    endfunction

    function automatic action_t act_arg(opcode_t op);
        action_t a;
        a.kind     = ACT_ARG;
        a.next_pos = POS_NUM;
        a.opcode   = op;
        return a;
    endfunction

    function automatic action_t act_err();
        action_t a;
        a.kind     = ACT_ERR;
        a.next_pos = POS_IDLE;
        a.opcode   = OP_PUSH;
        return a;
    endfunction

    function automatic action_t tree_step(pos_t pos, class_t cls);
        action_t r0;
        action_t r1;
        action_t r2;
        action_t r;
        r0 = act_err();
        r1 = act_err();
        r2 = act_err();
        unique case (pos)
            POS_IDLE: begin
                r0 = act_move(POS_S);  r1 = act_move(POS_T);  r2 = act_move(POS_L);
            end
            POS_S: begin
                r0 = act_arg(OP_PUSH); r1 = act_err();        r2 = act_move(POS_SL);
            end
            POS_SL: begin
                r0 = act_emit(OP_DUP); r1 = act_emit(OP_SWAP); r2 = act_emit(OP_POP);
            end
            POS_T: begin
                r0 = act_move(POS_TS); r1 = act_move(POS_TT); r2 = act_move(POS_TL);
            end
            POS_TS: begin
                r0 = act_move(POS_TSS); r1 = act_move(POS_TST); r2 = act_err();
            end
            POS_TSS: begin
                r0 = act_emit(OP_ADD); r1 = act_emit(OP_SUB); r2 = act_emit(OP_MUL);
            end
            POS_TST: begin
                r0 = act_emit(OP_DIV); r1 = act_emit(OP_REM); r2 = act_err();
            end
            POS_TT: begin
                r0 = act_emit(OP_STORE); r1 = act_emit(OP_RETRIEVE); r2 = act_err();
            end
            POS_TL: begin
                r0 = act_move(POS_TLS); r1 = act_move(POS_TLT); r2 = act_err();
            end
            POS_TLS: begin
                r0 = act_emit(OP_OUTC); r1 = act_emit(OP_OUTN); r2 = act_err();
            end
            POS_TLT: begin
                r0 = act_emit(OP_INC); r1 = act_emit(OP_INN); r2 = act_err();
            end
            POS_L: begin
                r0 = act_move(POS_LS); r1 = act_move(POS_LT); r2 = act_move(POS_LL);
            end
            POS_LS: begin
                r0 = act_arg(OP_LABEL); r1 = act_arg(OP_CALL); r2 = act_arg(OP_JUMP);
            end
            POS_LT: begin
                r0 = act_arg(OP_JZ); r1 = act_arg(OP_JNEG); r2 = act_emit(OP_RET);
            end
            POS_LL: begin
                r0 = act_err(); r1 = act_err(); r2 = act_emit(OP_END);
            end
            default: begin
                r0 = act_err(); r1 = act_err(); r2 = act_err();
            end
        endcase
        case (cls)
            CLS_SPACE: r = r0;
            CLS_TAB:   r = r1;
            default:   r = r2;
        endcase
        return r;
    endfunction

endpackage

`default_nettype wire

// ===== src/whitespace_instruction_decoder_unit.sv =====
// Whitespace instruction decoder: takes one program byte per transaction on the
// s_ stream (s_tlast marks the final byte) and gives one decoded instruction
// per transaction on the m_ stream. Bytes other than space, tab and newline
// are skipped. A classifier feeds a four-entry queue that drains into the
// decoder, which walks the prefix tree or shifts the number a byte at a time,
// so a byte is taken every cycle while m_ is not stalled; the queue and the
// output register lie between a completing byte and its result on m_. Back
// pressure on m_ fills the queue and then drops s_tready. An undefined prefix
// yields status 1 and the block then swallows all input silently until
// reset. Magnitudes saturate at 2^min(MAGNITUDE_BITS,31)-1 with status 2.
`default_nettype none

module whitespace_instruction_decoder_unit #(
    parameter int MAGNITUDE_BITS = wsid_pkg::DEFAULT_MAGNITUDE_BITS
) (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           s_tvalid,
    output logic                                s_tready,
    input  wire logic [wsid_pkg::S_TDATA_W-1:0] s_tdata,  // [7:0] character
    input  wire logic                           s_tlast,  // last
    output logic                                m_tvalid,
    input  wire logic                           m_tready,
    // [4:0] opcode, [36:5] argument, [37] has_argument, [39:38] status
    output logic [wsid_pkg::M_TDATA_W-1:0]      m_tdata
);
    import wsid_pkg::*;

    logic   queue_full;
    logic   queue_empty;
    logic   push;
    logic   pop;
    qitem_t push_item;
    qitem_t pop_item;

    wsid_front u_front (
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tlast    (s_tlast),
        .queue_full (queue_full),
        .push       (push),
        .push_item  (push_item)
    );

    wsid_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_item (push_item),
        .pop       (pop),
        .pop_item  (pop_item),
        .full      (queue_full),
        .empty     (queue_empty)
    );

    wsid_back #(
        .MAGNITUDE_BITS (MAGNITUDE_BITS)
    ) u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .queue_empty (queue_empty),
        .queue_item  (pop_item),
        .pop         (pop),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata)
    );

endmodule

`default_nettype wire

// ===== src/wsid_front.sv =====
`default_nettype none

module wsid_front (
    input  wire logic                           s_tvalid,
    output logic                                s_tready,
    input  wire logic [wsid_pkg::S_TDATA_W-1:0] s_tdata,  // [7:0] character
    input  wire logic                           s_tlast,  // last
    input  wire logic                           queue_full,
    output logic                                push,
    output wsid_pkg::qitem_t                    push_item
);
    import wsid_pkg::*;

    class_t cls;

    always_comb begin
        case (s_tdata)
            CHAR_SPACE:   cls = CLS_SPACE;
            CHAR_TAB:     cls = CLS_TAB;
            CHAR_NEWLINE: cls = CLS_NEWLINE;
            default:      cls = CLS_OTHER;
        endcase
    end

    assign s_tready       = !queue_full;
    assign push           = s_tvalid && !queue_full;
    assign push_item.cls  = cls;
    assign push_item.last = s_tlast;

endmodule

`default_nettype wire

// ===== src/wsid_queue.sv =====
`default_nettype none

module wsid_queue (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             push,
    input  wire wsid_pkg::qitem_t push_item,
    input  wire logic             pop,
    output wsid_pkg::qitem_t      pop_item,
    output logic                  full,
    output logic                  empty
);
    import wsid_pkg::*;

    qitem_t              mem_reg [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0] wptr_reg;
    logic [QUEUE_AW-1:0] rptr_reg;
    logic [QUEUE_CW-1:0] count_reg;
    logic [QUEUE_AW-1:0] wptr_next;
    logic [QUEUE_AW-1:0] rptr_next;
    logic [QUEUE_CW-1:0] count_next;

    assign full     = (count_reg == QUEUE_CW'(QUEUE_DEPTH));
    assign empty    = (count_reg == '0);
    assign pop_item = mem_reg[rptr_reg];

    always_comb begin
        wptr_next  = wptr_reg;
        rptr_next  = rptr_reg;
        count_next = count_reg;
        if (push) begin
            wptr_next = (wptr_reg == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0 : wptr_reg + 1'b1;
        end
        if (pop) begin
            rptr_next = (rptr_reg == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0 : rptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wptr_reg  <= '0;
            rptr_reg  <= '0;
            count_reg <= '0;
        end else begin
            wptr_reg  <= wptr_next;
            rptr_reg  <= rptr_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wptr_reg] <= push_item;
        end
    end

endmodule

`default_nettype wire

// ===== src/wsid_back.sv =====
`default_nettype none

module wsid_back #(
    parameter int MAGNITUDE_BITS = wsid_pkg::DEFAULT_MAGNITUDE_BITS
) (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           queue_empty,
    input  wire wsid_pkg::qitem_t               queue_item,
    output logic                                pop,
    output logic                                m_tvalid,
    input  wire logic                           m_tready,
    output logic [wsid_pkg::M_TDATA_W-1:0]      m_tdata
);
    import wsid_pkg::*;

    localparam int MAG_W = (MAGNITUDE_BITS < 31) ? MAGNITUDE_BITS : 31;

    pos_t             pos_reg,     pos_next;
    opcode_t          pending_reg, pending_next;
    logic             sign_reg,    sign_next;
    logic             seen_reg,    seen_next;
    logic             ovf_reg,     ovf_next;
    logic [MAG_W-1:0] mag_reg,     mag_next;
    logic             halted_reg,  halted_next;
    logic             out_valid_reg, out_valid_next;
    result_t          out_reg,     out_next;

    logic             advance;
    logic             res_valid;
    result_t          res;
    action_t          act;
    logic [ARG_W-1:0] mag_ext;

    assign advance  = !queue_empty && (!out_valid_reg || m_tready);
    assign pop      = advance;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_reg;
    assign mag_ext  = ARG_W'(mag_reg);
    assign act      = tree_step(pos_reg, queue_item.cls);

    always_comb begin
        pos_next     = pos_reg;
        pending_next = pending_reg;
        sign_next    = sign_reg;
        seen_next    = seen_reg;
        ovf_next     = ovf_reg;
        mag_next     = mag_reg;
        halted_next  = halted_reg;
        res_valid    = 1'b0;
        res.opcode       = OP_PUSH;
        res.argument     = '0;
        res.has_argument = 1'b0;
        res.status       = ST_OK;

        if (advance && !halted_reg) begin
            if (queue_item.cls != CLS_OTHER) begin
                if (pos_reg == POS_NUM) begin
                    if (queue_item.cls != CLS_NEWLINE) begin
                        if (!seen_reg) begin
                            sign_next = (queue_item.cls == CLS_TAB);
                        end else if (mag_reg[MAG_W-1]) begin
                            mag_next = '1;
                            ovf_next = 1'b1;
                        end else begin
                            mag_next = {mag_reg[MAG_W-2:0], queue_item.cls == CLS_TAB};
                        end
                        seen_next = 1'b1;
                    end else begin
                        res_valid        = 1'b1;
                        res.opcode       = pending_reg;
                        res.has_argument = 1'b1;
                        res.status       = ovf_reg ? ST_OVERFLOW : ST_OK;
                        if (!seen_reg) begin
                            res.argument = EMPTY_NUMBER;
                        end else if (sign_reg) begin
                            res.argument = ARG_W'(0) - mag_ext;
                        end else begin
                            res.argument = mag_ext;
                        end
                        pos_next = POS_IDLE;
                    end
                end else begin
                    unique case (act.kind)
                        ACT_ERR: begin
                            res_valid   = 1'b1;
                            res.status  = ST_UNDEFINED;
                            halted_next = 1'b1;
                            pos_next    = POS_IDLE;
                        end
                        ACT_ARG: begin
                            pending_next = act.opcode;
                            pos_next     = POS_NUM;
                        end
                        ACT_EMIT: begin
                            res_valid  = 1'b1;
                            res.opcode = act.opcode;
                            pos_next   = POS_IDLE;
                        end
                        default: begin
                            pos_next = act.next_pos;
                        end
                    endcase
                    sign_next = 1'b0;
                    seen_next = 1'b0;
                    ovf_next  = 1'b0;
                    mag_next  = '0;
                end
            end
            if (queue_item.last && !res_valid) begin
                res_valid  = 1'b1;
                res.status = ST_INCOMPLETE;
                pos_next   = POS_IDLE;
            end
            if (res_valid) begin
                sign_next = 1'b0;
                seen_next = 1'b0;
                ovf_next  = 1'b0;
                mag_next  = '0;
            end
        end
    end

    always_comb begin
        out_valid_next = out_valid_reg;
        out_next       = out_reg;
        if (m_tready) begin
            out_valid_next = 1'b0;
        end
        if (advance && res_valid) begin
            out_valid_next = 1'b1;
            out_next       = res;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg       <= POS_IDLE;
            halted_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
            seen_reg      <= 1'b0;
            ovf_reg       <= 1'b0;
        end else begin
            pos_reg       <= pos_next;
            halted_reg    <= halted_next;
            out_valid_reg <= out_valid_next;
            seen_reg      <= seen_next;
            ovf_reg       <= ovf_next;
        end
    end

    always_ff @(posedge aclk) begin
        pending_reg <= pending_next;
        sign_reg    <= sign_next;
        mag_reg     <= mag_next;
        out_reg     <= out_next;
    end

    a_halt_with_error: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(halted_reg) |-> out_valid_reg && out_reg.status == ST_UNDEFINED)
        else $error("halt entered without an undefined-command result");

    a_silent_when_halted: assert property (@(posedge aclk) disable iff (!aresetn)
        halted_reg |-> !(advance && res_valid))
        else $error("result produced while halted");

    a_unused_argument_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg && !out_reg.has_argument |-> out_reg.argument == '0)
        else $error("argument nonzero without a number");

    a_argument_status: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg && out_reg.has_argument
            |-> out_reg.status == ST_OK || out_reg.status == ST_OVERFLOW)
        else $error("numbered result with error status");

endmodule

`default_nettype wire
